@@ rtl/core/ctwa_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctwa_pkg: shared types and constants of the peer table with aging
// Holds the operation codes, register indexes, entry layout and the
// command and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package ctwa_pkg;

   // Field widths of one request and one table entry.
   localparam int OP_W    = 2;
   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 16;
   localparam int SEQ_W   = 32;
   localparam int STAMP_W = 32;
   localparam int SEL_W   = 9;
   localparam int SLOT_W  = 9;

   // Configuration registers.
   localparam int EIU_W   = 10;
   localparam int AGE_W   = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_LIMIT      = 1'b1;

   localparam logic [EIU_W-1:0] EIU_RESET       = 10'd512;
   localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd120;

   // Operation codes carried in the request's tuser.
   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_UPDATE = 2'd2,
      OP_REAP   = 2'd3
   } ctwa_op_type;

   // One table entry as stored in the RAM.
   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [SEQ_W-1:0]   seq;
      logic [PORT_W-1:0]  port;
      logic [ADDR_W-1:0]  addr;
   } ctwa_entry_type;

   localparam int ENTRY_W = $bits(ctwa_entry_type);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;   // write one zero entry of the clearing pass
      logic load;       // capture a request beat and restart the scan
      logic scan_en;    // keep the table scan running
      logic upd_wr;     // write the captured entry at the selected slot
      logic out_load;   // move the result into the output register
   } ctwa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last; // the clearing pass writes its last entry
      logic scan_done;  // scan found its slot or ran past the scan length
   } ctwa_sts_type;

endpackage

@@ rtl/core/client_table_with_aging_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// client_table_with_aging_core: peer table with lookup, add, update, reap
// Top level joining the sequencing controller and the table datapath.
// ---------------------------------------------------------------------------
// Usage:
// A request beat on req_* carries the operation in req_tuser and the entry
// fields in req_tdata. Every request yields exactly one result beat on rsp_*.
// Lookup, add and reap scan the first entries_in_use slots (saturated at
// TABLE_DEPTH) through the single read port of the entry RAM, one slot per
// cycle. The read is registered; lookup and add stop at the first slot
// that matches or is free. One request is in work at a time; the next one
// is taken once the previous result sits in the output register and the
// controller is back in idle.
// Reset starts a clearing pass that writes every RAM slot to zero, one per
// cycle, so no request is taken until the pass is done; csr writes are
// taken at any time and must only be issued while idle.
// When the receiver stalls, the result beat holds in the output register;
// one more request is accepted and worked, and then waits for that slot.
// ---------------------------------------------------------------------------
module client_table_with_aging_core #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: peer_addr[31:0], peer_port[47:32], peer_seq[79:48],
   //        stamp_sec[111:80], slot_sel[120:112], zero padding[127:121]
   input  logic [127:0] req_tdata,
   // tuser: opcode[1:0]
   input  logic [1:0]   req_tuser,
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: hit[0], slot_index[9:1], table_full[10], zero padding[15:11]
   output logic [15:0]  rsp_tdata,
   // Configuration write port.
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [15:0]  csr_wdata
);
   import ctwa_pkg::*;

   ctwa_cmd_type cmd;
   ctwa_sts_type sts;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_slot;
   logic              rsp_full;

   ctwa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   ctwa_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_op    (req_tuser),
      .req_addr  (req_tdata[31:0]),
      .req_port  (req_tdata[47:32]),
      .req_seq   (req_tdata[79:48]),
      .req_stamp (req_tdata[111:80]),
      .req_sel   (req_tdata[120:112]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_hit   (rsp_hit),
      .rsp_slot  (rsp_slot),
      .rsp_full  (rsp_full)
   );

   // Pack the result beat.
   assign rsp_tdata = {5'b0, rsp_full, rsp_slot, rsp_hit};

endmodule

@@ rtl/core/ctwa_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctwa_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ctwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ rtl/core/ctwa_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctwa_ctrl: sequencing controller of the peer table
// Runs the clearing pass after reset, takes one request beat at a time,
// steers the scan or the update write and hands the result to the output.
// ---------------------------------------------------------------------------
module ctwa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ctwa_pkg::OP_W-1:0] req_op,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output ctwa_pkg::ctwa_cmd_type cmd,
   input  ctwa_pkg::ctwa_sts_type sts
);
   import ctwa_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (ctwa_op_type'(req_op) == OP_UPDATE) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_done) begin
               state_in = ST_RESULT;
            end
         end
         ST_UPDATE: begin
            cmd.upd_wr = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            // The output register takes the result once it is empty or drained.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output beat is held until the receiver takes it.
   always_comb begin
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_tready);
   end

   // State and registered output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/ctwa_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ctwa_dp: datapath of the peer table
// Holds the configuration registers, the captured request, the entry RAM,
// the scan counter with its compare stage and the result registers.
// ---------------------------------------------------------------------------
module ctwa_dp #(
   parameter int TABLE_DEPTH = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctwa_pkg::ctwa_cmd_type         cmd,
   output ctwa_pkg::ctwa_sts_type         sts,
   input  logic [ctwa_pkg::OP_W-1:0]      req_op,
   input  logic [ctwa_pkg::ADDR_W-1:0]    req_addr,
   input  logic [ctwa_pkg::PORT_W-1:0]    req_port,
   input  logic [ctwa_pkg::SEQ_W-1:0]     req_seq,
   input  logic [ctwa_pkg::STAMP_W-1:0]   req_stamp,
   input  logic [ctwa_pkg::SEL_W-1:0]     req_sel,
   input  logic                           csr_we,
   input  logic [ctwa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctwa_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                           rsp_hit,
   output logic [ctwa_pkg::SLOT_W-1:0]    rsp_slot,
   output logic                           rsp_full
);
   import ctwa_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int LEN_W   = (CNT_W > EIU_W) ? CNT_W : EIU_W;
   localparam int SELX_W  = ((IDX_W > SEL_W) ? IDX_W : SEL_W) + 1;
   localparam int SLOTX_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

   // Configuration registers.
   logic [EIU_W-1:0] eiu_ff;
   logic [AGE_W-1:0] age_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eiu_ff       <= EIU_RESET;
         age_limit_ff <= AGE_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRIES_IN_USE: eiu_ff       <= csr_wdata[EIU_W-1:0];
            CSR_AGE_LIMIT:      age_limit_ff <= csr_wdata[AGE_W-1:0];
            default:            ;
         endcase
      end
   end

   // Scan length saturates at the table depth.
   logic [LEN_W-1:0] eiu_ext;
   logic [CNT_W-1:0] scan_len;

   always_comb begin
      eiu_ext  = LEN_W'(eiu_ff);
      scan_len = (eiu_ext > LEN_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                 : eiu_ext[CNT_W-1:0];
   end

   // Captured request beat.
   ctwa_op_type    op_ff;
   ctwa_entry_type item_ff;
   logic [SEL_W-1:0] sel_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff         <= ctwa_op_type'(req_op);
         item_ff.addr  <= req_addr;
         item_ff.port  <= req_port;
         item_ff.seq   <= req_seq;
         item_ff.stamp <= req_stamp;
         sel_ff        <= req_sel;
      end
   end

   // Scan and clear counter, compare stage and hit flag.
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] slot_ff;
   logic             issue;
   logic             act;
   logic             found;

   logic [ENTRY_W-1:0] ram_rd_data;
   ctwa_entry_type     rd_entry;
   logic               match;
   logic               is_free;
   logic signed [STAMP_W:0] age;
   logic               stale;

   always_comb begin
      rd_entry = ctwa_entry_type'(ram_rd_data);
      match    = (rd_entry.addr == item_ff.addr) && (rd_entry.port == item_ff.port);
      is_free  = (rd_entry.seq == '0);
      // Age is current time minus stamp, as a signed value one bit wider.
      age      = $signed({1'b0, item_ff.stamp}) - $signed({1'b0, rd_entry.stamp});
      stale    = age > $signed((STAMP_W + 1)'(age_limit_ff));

      issue = cmd.scan_en && (rd_idx_ff < scan_len) && !hit_ff;
      act   = chk_vld_ff && !hit_ff;
      found = act && (((op_ff == OP_LOOKUP) && match) || ((op_ff == OP_ADD) && is_free));

      rd_idx_in = rd_idx_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
      end else if (cmd.clear_en || issue) begin
         rd_idx_in = rd_idx_ff + 1'b1;
      end

      chk_vld_in = issue;

      hit_in = hit_ff;
      if (cmd.load) begin
         hit_in = 1'b0;
      end else if (found) begin
         hit_in = 1'b1;
      end

      sts.clear_last = (rd_idx_ff == CNT_W'(TABLE_DEPTH - 1));
      sts.scan_done  = hit_ff || (!chk_vld_ff && (rd_idx_ff >= scan_len));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff  <= '0;
         chk_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         rd_idx_ff  <= rd_idx_in;
         chk_vld_ff <= chk_vld_in;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= rd_idx_ff[IDX_W-1:0];
      if (found) begin
         slot_ff <= chk_idx_ff;
      end
   end

   // Write port selection: clearing pass, update, add placement, reap.
   logic [SELX_W-1:0]  sel_ext;
   logic               sel_ok;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   ctwa_entry_type     ram_wr_entry;

   always_comb begin
      sel_ext      = SELX_W'(sel_ff);
      sel_ok       = sel_ext < SELX_W'(TABLE_DEPTH);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = chk_idx_ff;
      ram_wr_entry = '0;
      priority if (cmd.clear_en) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = rd_idx_ff[IDX_W-1:0];
      end else if (cmd.upd_wr) begin
         ram_wr_en    = sel_ok;
         ram_wr_addr  = sel_ext[IDX_W-1:0];
         ram_wr_entry = item_ff;
      end else if (act && (op_ff == OP_ADD) && is_free) begin
         ram_wr_en    = 1'b1;
         ram_wr_entry = item_ff;
      end else if (act && (op_ff == OP_REAP) && !is_free && stale) begin
         ram_wr_en = 1'b1;
      end else begin
         ram_wr_en = 1'b0;
      end
   end

   ctwa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Output register of the result beat.
   logic [SLOTX_W-1:0] slot_ext;

   always_comb begin
      slot_ext = SLOTX_W'(slot_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_hit  <= hit_ff;
         rsp_slot <= hit_ff ? slot_ext[SLOT_W-1:0] : '0;
         rsp_full <= (op_ff == OP_ADD) && !hit_ff;
      end
   end

endmodule
